// File: design/vrd_pkg.sv
// Shared types, widths and constants for the degree-based CORDIC vector rotator.
// Used by every module in the design; depends on nothing.
package vrd_pkg;

    // Field widths.
    localparam int XW = 32;          // Q16.16 vector components
    localparam int AW = 26;          // Q9.16 angle in degrees
    localparam int GUARD = 4;        // extra fraction bits in the vector datapath
    localparam int VW = 40;          // vector datapath width, Q16.(16+GUARD) with headroom
    localparam int WW = 25;          // wrapped angle width, covers [-180, 180) in Q.16

    // Angle constants in Q.16 degrees.
    localparam int HALF_TURN = 180;
    localparam logic signed [AW:0] FULL_Q16 = 27'sd23592960;
    localparam logic signed [AW:0] HALF_Q16 = 27'sd11796480;
    localparam logic signed [AW:0] NEG_HALF_Q16 = -27'sd11796480;
    localparam logic signed [WW-1:0] HALF_W = 25'sd11796480;
    localparam logic signed [WW-1:0] QUARTER_W = 25'sd5898240;
    localparam logic signed [WW-1:0] NEG_QUARTER_W = -25'sd5898240;

    // Arctangent table, atan(2^-i) in degrees as Q.24.
    localparam int ATAN_ENTRIES = 30;
    localparam logic [29:0] ATAN_DEG_Q24 [ATAN_ENTRIES] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
        30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
        30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
        30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115,       30'd57,
        30'd29,        30'd14,        30'd7,         30'd4,         30'd2
    };

    // Gain compensation: 1/K as Q0.24, applied as a split multiply.
    localparam int GAIN_W = 24;
    localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10188014;
    localparam int SPLIT = 20;       // low part of the vector word in the split multiply
    localparam int PW = 44;          // width of each partial product
    localparam int SUMW = 64;        // full product width
    localparam int RSHIFT = GAIN_W + GUARD;
    localparam logic [SUMW-1:0] ROUND_HALF = 64'd1 << (RSHIFT - 1);

    localparam logic signed [XW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [XW-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic                 sat;
    } result_t;

    // Arctangent step rounded half up to frac fraction bits.
    function automatic logic [29:0] atan_step(input int unsigned idx, input int unsigned frac);
        logic [30:0] t;
        int unsigned drop;
        drop = 24 - frac;
        t = {1'b0, ATAN_DEG_Q24[idx]};
        if (drop > 0) begin
            t = (t + (31'd1 << (drop - 1))) >> drop;
        end
        return t[29:0];
    endfunction

endpackage

// File: design/vrd_prep.sv
// Angle wrap and quadrant fold, two register stages ahead of the CORDIC chain.
// Depends on vrd_pkg.
module vrd_prep #(
    parameter int FRAC_BITS = 16,
    localparam int ZW = FRAC_BITS + 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [vrd_pkg::XW-1:0]  x_in,
    input  logic signed [vrd_pkg::XW-1:0]  y_in,
    input  logic signed [vrd_pkg::AW-1:0]  angle_deg,
    output logic                           out_valid,
    output logic signed [vrd_pkg::VW-1:0]  x_out,
    output logic signed [vrd_pkg::VW-1:0]  y_out,
    output logic signed [ZW-1:0]           z_out
);

    localparam int EXT = vrd_pkg::VW - vrd_pkg::XW - vrd_pkg::GUARD;

    logic                          v1_reg;
    logic signed [vrd_pkg::XW-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [vrd_pkg::WW-1:0] a1_reg, a1_next;
    logic                          v2_reg;
    logic signed [vrd_pkg::VW-1:0] x2_reg, x2_next, y2_reg, y2_next;
    logic signed [ZW-1:0]          z2_reg, z2_next;

    logic signed [vrd_pkg::AW:0]   a_ext, a_wrap;
    logic signed [vrd_pkg::WW-1:0] a_fold;
    logic signed [vrd_pkg::VW-1:0] vx, vy;
    logic                          flip;

    // Stage 1: the input range is under 1.5 turns, so one add brings it to [-180, 180).
    always_comb begin
        a_ext = {angle_deg[vrd_pkg::AW-1], angle_deg};
        if (a_ext >= vrd_pkg::HALF_Q16) begin
            a_wrap = a_ext - vrd_pkg::FULL_Q16;
        end else if (a_ext < vrd_pkg::NEG_HALF_Q16) begin
            a_wrap = a_ext + vrd_pkg::FULL_Q16;
        end else begin
            a_wrap = a_ext;
        end
        a1_next = a_wrap[vrd_pkg::WW-1:0];
        x1_next = x_in;
        y1_next = y_in;
    end

    // Stage 2: a half turn is a negation of the vector, which brings the angle to [-90, 90].
    always_comb begin
        vx = {{EXT{x1_reg[vrd_pkg::XW-1]}}, x1_reg, {vrd_pkg::GUARD{1'b0}}};
        vy = {{EXT{y1_reg[vrd_pkg::XW-1]}}, y1_reg, {vrd_pkg::GUARD{1'b0}}};
        flip = 1'b0;
        a_fold = a1_reg;
        if (a1_reg > vrd_pkg::QUARTER_W) begin
            flip = 1'b1;
            a_fold = a1_reg - vrd_pkg::HALF_W;
        end else if (a1_reg < vrd_pkg::NEG_QUARTER_W) begin
            flip = 1'b1;
            a_fold = a1_reg + vrd_pkg::HALF_W;
        end
        x2_next = flip ? -vx : vx;
        y2_next = flip ? -vy : vy;
    end

    generate
        if (FRAC_BITS >= 16) begin : g_up
            assign z2_next = ZW'(a_fold) <<< (FRAC_BITS - 16);
        end else begin : g_down
            assign z2_next = ZW'(a_fold >>> (16 - FRAC_BITS));
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            a1_reg <= a1_next;
            x2_reg <= x2_next;
            y2_reg <= y2_next;
            z2_reg <= z2_next;
        end
    end

    assign out_valid = v2_reg;
    assign x_out     = x2_reg;
    assign y_out     = y2_reg;
    assign z_out     = z2_reg;

endmodule

// File: design/vrd_micro_rot.sv
// One registered CORDIC micro-rotation in rotation mode.
// Depends on vrd_pkg; the arctangent step comes in as a parameter.
module vrd_micro_rot #(
    parameter int          FRAC_BITS = 16,
    parameter int          IDX = 0,
    parameter logic [29:0] STEP = 30'd0,
    localparam int         ZW = FRAC_BITS + 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [vrd_pkg::VW-1:0] x_in,
    input  logic signed [vrd_pkg::VW-1:0] y_in,
    input  logic signed [ZW-1:0]          z_in,
    output logic                          out_valid,
    output logic signed [vrd_pkg::VW-1:0] x_out,
    output logic signed [vrd_pkg::VW-1:0] y_out,
    output logic signed [ZW-1:0]          z_out
);

    localparam logic signed [ZW-1:0] STEP_Z = ZW'(STEP);

    logic                          v_reg;
    logic signed [vrd_pkg::VW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]          z_reg, z_next;
    logic signed [vrd_pkg::VW-1:0] dx, dy;

    // Arithmetic shifts floor toward minus infinity.
    always_comb begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (!z_in[ZW-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - STEP_Z;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + STEP_Z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = v_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

// File: design/vrd_gain.sv
// Gain compensation: split multiply by 1/K, then round half up and saturate to 32 bits.
// Two register stages; depends on vrd_pkg.
module vrd_gain (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [vrd_pkg::VW-1:0] x_in,
    input  logic signed [vrd_pkg::VW-1:0] y_in,
    output logic                          out_valid,
    output vrd_pkg::result_t              result
);

    localparam int HW = vrd_pkg::VW - vrd_pkg::SPLIT;
    localparam int TOP = vrd_pkg::SUMW - vrd_pkg::RSHIFT;   // width after the shift

    logic                   va_reg, vb_reg;
    logic [vrd_pkg::PW-1:0] ph_reg [2];
    logic [vrd_pkg::PW-1:0] ph_next [2];
    logic [vrd_pkg::PW-1:0] pl_reg [2];
    logic [vrd_pkg::PW-1:0] pl_next [2];
    logic signed [vrd_pkg::XW-1:0] r_next [2];
    logic                   sat_lane [2];
    vrd_pkg::result_t       res_reg, res_next;

    logic signed [vrd_pkg::VW-1:0] comp [2];
    logic [vrd_pkg::SUMW-1:0]      sum [2];
    logic signed [TOP-1:0]         shifted [2];

    assign comp[0] = x_in;
    assign comp[1] = y_in;

    // Stage A: the vector word is cut into a signed high part and an unsigned low part.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            ph_next[k] = {{(vrd_pkg::PW - HW){comp[k][vrd_pkg::VW-1]}},
                          comp[k][vrd_pkg::VW-1:vrd_pkg::SPLIT]}
                       * {{(vrd_pkg::PW - vrd_pkg::GAIN_W){1'b0}}, vrd_pkg::GAIN_Q24};
            pl_next[k] = {{(vrd_pkg::PW - vrd_pkg::SPLIT){1'b0}},
                          comp[k][vrd_pkg::SPLIT-1:0]}
                       * {{(vrd_pkg::PW - vrd_pkg::GAIN_W){1'b0}}, vrd_pkg::GAIN_Q24};
        end
    end

    // Stage B: recombine, round, and clamp when the top bits disagree.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            sum[k] = {ph_reg[k], {vrd_pkg::SPLIT{1'b0}}}
                   + {{(vrd_pkg::SUMW - vrd_pkg::PW){1'b0}}, pl_reg[k]}
                   + vrd_pkg::ROUND_HALF;
            shifted[k] = sum[k][vrd_pkg::SUMW-1:vrd_pkg::RSHIFT];
            sat_lane[k] = !((&shifted[k][TOP-1:vrd_pkg::XW-1])
                            || !(|shifted[k][TOP-1:vrd_pkg::XW-1]));
            if (!sat_lane[k]) begin
                r_next[k] = shifted[k][vrd_pkg::XW-1:0];
            end else if (shifted[k][TOP-1]) begin
                r_next[k] = vrd_pkg::SAT_MIN;
            end else begin
                r_next[k] = vrd_pkg::SAT_MAX;
            end
        end
        res_next.x   = r_next[0];
        res_next.y   = r_next[1];
        res_next.sat = sat_lane[0] | sat_lane[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg  <= ph_next;
            pl_reg  <= pl_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = vb_reg;
    assign result    = res_reg;

endmodule

// File: design/vector_rotate_degrees.sv
// Rotates a Q16.16 vector counterclockwise by a Q9.16 angle in degrees through an unrolled
// CORDIC pipeline. One beat is accepted per cycle while the spare output entry is free. A beat
// passes two angle wrap and fold stages, min(ITERATIONS, 30) micro-rotation stages, two gain
// stages and the output register. A two-entry output buffer lets the pipeline keep taking
// beats while a result waits; the whole pipeline holds only once the second entry fills.
// Results that overflow 32 bits are clamped and flagged in m_tuser.
// Depends on vrd_pkg, vrd_prep, vrd_micro_rot and vrd_gain.
module vector_rotate_degrees #(
    parameter int ITERATIONS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // x_in [31:0], y_in [63:32], angle_deg [89:64], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // x_out [31:0], y_out [63:32]
    output logic [0:0]  m_tuser    // saturated [0]
);

    localparam int NUM = (ITERATIONS < vrd_pkg::ATAN_ENTRIES) ? ITERATIONS
                                                             : vrd_pkg::ATAN_ENTRIES;
    localparam int ZW = FRAC_BITS + 10;

    logic                          en;
    logic                          vs [NUM+1];
    logic signed [vrd_pkg::VW-1:0] xs [NUM+1];
    logic signed [vrd_pkg::VW-1:0] ys [NUM+1];
    logic signed [ZW-1:0]          zs [NUM+1];

    logic             gain_valid;
    vrd_pkg::result_t gain_res;
    logic             push;

    logic             head_valid_reg, head_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    vrd_pkg::result_t head_reg, head_next;
    vrd_pkg::result_t skid_reg, skid_next;

    // The pipeline moves unless the spare buffer entry is occupied.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    vrd_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .x_in      (s_tdata[31:0]),
        .y_in      (s_tdata[63:32]),
        .angle_deg (s_tdata[89:64]),
        .out_valid (vs[0]),
        .x_out     (xs[0]),
        .y_out     (ys[0]),
        .z_out     (zs[0])
    );

    generate
        for (genvar i = 0; i < NUM; i++) begin : g_rot
            vrd_micro_rot #(
                .FRAC_BITS (FRAC_BITS),
                .IDX       (i),
                .STEP      (vrd_pkg::atan_step(i, FRAC_BITS))
            ) u_rot (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (vs[i]),
                .x_in      (xs[i]),
                .y_in      (ys[i]),
                .z_in      (zs[i]),
                .out_valid (vs[i+1]),
                .x_out     (xs[i+1]),
                .y_out     (ys[i+1]),
                .z_out     (zs[i+1])
            );
        end
    endgenerate

    vrd_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vs[NUM]),
        .x_in      (xs[NUM]),
        .y_in      (ys[NUM]),
        .out_valid (gain_valid),
        .result    (gain_res)
    );

    assign push = en && gain_valid;

    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                head_next       = gain_res;
                head_valid_next = push;
            end
        end else if (push) begin
            skid_next       = gain_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid   = head_valid_reg;
    assign m_tdata    = {head_reg.y, head_reg.x};
    assign m_tuser[0] = head_reg.sat;

`ifndef NO_ASSERTIONS
    // The spare entry is only ever used behind a held output beat.
    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid while output register empty");

    // The spare entry fills only when the output beat was stalled.
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(head_valid_reg && !m_tready))
        else $error("skid entry filled without an output stall");

    // A flagged result carries a clamped value in at least one component.
    a_sat_means_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (head_reg.x == vrd_pkg::SAT_MAX || head_reg.x == vrd_pkg::SAT_MIN ||
             head_reg.y == vrd_pkg::SAT_MAX || head_reg.y == vrd_pkg::SAT_MIN))
        else $error("saturated flag set without a clamped component");
`endif

endmodule
